// File: src/ecad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecad_pkg
// shared types and constants of the eye-closure alarm detector
// ----------------------------------------------------------------------------
package ecad_pkg;

    localparam int COORD_BITS_DEF      = 12;
    localparam int RATIO_FRAC_BITS_DEF = 12;

    localparam int FIELD_W    = 24;
    localparam int RATIO_W    = 16;
    localparam int COUNT_W    = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RATIO_THRESHOLD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_FRAMES    = CFG_IDX_W'(1);

    localparam logic [RATIO_W-1:0] RATIO_THRESHOLD_RST = RATIO_W'(369);
    localparam logic [COUNT_W-1:0] ALARM_FRAMES_RST    = COUNT_W'(48);

    localparam logic [RATIO_W-1:0] RATIO_MAX = {RATIO_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic [FIELD_W-1:0] left_p0;
        logic [FIELD_W-1:0] left_p1;
        logic [FIELD_W-1:0] left_p2;
        logic [FIELD_W-1:0] left_p3;
        logic [FIELD_W-1:0] left_p4;
        logic [FIELD_W-1:0] left_p5;
        logic [FIELD_W-1:0] right_p0;
        logic [FIELD_W-1:0] right_p1;
        logic [FIELD_W-1:0] right_p2;
        logic [FIELD_W-1:0] right_p3;
        logic [FIELD_W-1:0] right_p4;
        logic [FIELD_W-1:0] right_p5;
    } t_frame;

    typedef struct packed {
        logic [RATIO_W-1:0] avg_ratio;
        logic               eye_closed;
        logic [COUNT_W-1:0] closed_count;
        logic               alarm;
    } t_result;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } t_cfg;

    // sequencing strobes for the serial units
    typedef struct packed {
        logic load;
        logic step;
    } t_seq_ctl;

endpackage

// File: src/ecad_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecad_chan_if
// valid/ready channel carrying one payload beat of type T
// ----------------------------------------------------------------------------
interface ecad_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/ecad_sqr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecad_sqr
// bit-serial squarer: one multiplier bit per step, COORD_BITS steps
// ----------------------------------------------------------------------------
module ecad_sqr #(
    parameter int COORD_BITS = 12
) (
    input  logic                    i_clk,
    input  ecad_pkg::t_seq_ctl      i_ctl,
    input  logic [COORD_BITS-1:0]   i_d,
    output logic [2*COORD_BITS-1:0] o_sq
);
    import ecad_pkg::*;

    logic [COORD_BITS-1:0]   r_d;
    logic [2*COORD_BITS-1:0] r_p;
    logic [COORD_BITS:0]     n_sum;

    // upper half accumulates, lower half shifts the multiplier out
    always_comb begin
        n_sum = {1'b0, r_p[2*COORD_BITS-1:COORD_BITS]}
              + (r_p[0] ? {1'b0, r_d} : {(COORD_BITS+1){1'b0}});
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_d <= i_d;
            r_p <= {{COORD_BITS{1'b0}}, i_d};
        end else if (i_ctl.step) begin
            r_p <= {n_sum, r_p[COORD_BITS-1:1]};
        end
    end

    assign o_sq = r_p;

endmodule

// File: src/ecad_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecad_div
// restoring divider for one eye ratio, one quotient bit per step
// ----------------------------------------------------------------------------
module ecad_div #(
    parameter int COORD_BITS      = 12,
    parameter int RATIO_FRAC_BITS = 12
) (
    input  logic                      i_clk,
    input  ecad_pkg::t_seq_ctl        i_ctl,
    input  logic [2*COORD_BITS+1:0]   i_ab,
    input  logic [2*COORD_BITS:0]     i_c,
    output logic [ecad_pkg::RATIO_W-1:0] o_q
);
    import ecad_pkg::*;

    localparam int SH = (RATIO_FRAC_BITS > RATIO_W) ? RATIO_FRAC_BITS : RATIO_W;
    localparam int WR = 2*COORD_BITS + 2 + SH;

    logic [WR-1:0]      r_rem;
    logic [WR-1:0]      r_dsh;
    logic [RATIO_W-1:0] r_q;
    logic               r_sat;

    logic [WR-1:0] n_num;
    logic [WR-1:0] n_lim;
    logic          n_ge;

    always_comb begin
        n_num = WR'({i_ab, {RATIO_FRAC_BITS{1'b0}}});
        // quotient overflows when num >= (2c) << ratio width
        n_lim = WR'({i_c, {(RATIO_W+1){1'b0}}});
        n_ge  = (r_rem >= r_dsh);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_sat <= (i_c == '0) || (n_num >= n_lim);
            r_rem <= n_num;
            r_dsh <= WR'({i_c, {RATIO_W{1'b0}}});
            r_q   <= '0;
        end else if (i_ctl.step) begin
            if (n_ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_dsh <= {1'b0, r_dsh[WR-1:1]};
            r_q   <= {r_q[RATIO_W-2:0], n_ge};
        end
    end

    assign o_q = r_sat ? RATIO_MAX : r_q;

endmodule

// File: src/eye_closure_alarm_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eye_closure_alarm_detector
// eye aspect ratio from two sets of eye landmarks, closed-eye frame counter
// and drowsiness alarm
// ----------------------------------------------------------------------------
// One frame beat carries six landmark points per eye, x in the low
// COORD_BITS bits of each field and y in the next COORD_BITS bits. For each
// eye the block squares the six coordinate differences in bit-serial
// squarers (one multiplier bit per cycle), forms A+B and C, and divides
// (A+B)/(2C) in a restoring divider that yields one quotient bit per cycle,
// saturating to the maximum when C is zero or the ratio overflows. The two
// ratios are averaged and compared with ratio_threshold; consecutive closed
// frames are counted (saturating) and alarm is set when the count reaches
// alarm_frames. Each frame beat gives exactly one result beat. After a
// frame is accepted the squarers run their pass, the A+B and C sums are
// registered, the dividers are loaded and run, and the done state writes
// the result register once it is free, waiting there while an earlier
// result is still held. One frame is in flight at a time; the next frame
// is taken while an earlier result still waits in the output register.
// Configuration writes are always accepted and are meant for when no
// frame is in flight.
// ----------------------------------------------------------------------------
module eye_closure_alarm_detector #(
    parameter int COORD_BITS      = ecad_pkg::COORD_BITS_DEF,
    parameter int RATIO_FRAC_BITS = ecad_pkg::RATIO_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ecad_chan_if.sink   i_frame,
    ecad_chan_if.source o_result,
    ecad_chan_if.sink   i_cfg
);
    import ecad_pkg::*;

    localparam int CB     = COORD_BITS;
    localparam int NLANE  = 12;
    localparam int MAXSTP = (CB > RATIO_W) ? CB : RATIO_W;
    localparam int CNT_W  = $clog2(MAXSTP);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_SUM,
        S_LOAD,
        S_DIV,
        S_DONE
    } t_state;

    t_state r_state;
    logic [CNT_W-1:0] r_cnt;

    // configuration registers
    logic [RATIO_W-1:0] r_ratio_threshold;
    logic [COUNT_W-1:0] r_alarm_frames;
    logic [COUNT_W-1:0] r_closed_frames;

    // per-eye sums
    logic [2*CB+1:0] r_ab [2];
    logic [2*CB:0]   r_c  [2];

    logic          r_out_valid;
    t_result       r_out;

    logic          w_accept;
    logic          w_out_free;
    t_seq_ctl      w_sq_ctl;
    t_seq_ctl      w_div_ctl;
    logic [31:0]   w_pts [NLANE];
    logic [2*CB-1:0] w_sq [NLANE];
    logic [RATIO_W-1:0] w_ratio [2];

    logic [RATIO_W:0]   n_avg_sum;
    logic [RATIO_W-1:0] n_avg;
    logic               n_closed;
    logic [COUNT_W-1:0] n_count;
    logic               n_alarm;
    logic [2*CB+1:0]    n_ab [2];
    logic [2*CB:0]      n_c  [2];

    assign w_accept   = i_frame.valid && i_frame.ready;
    assign w_out_free = !r_out_valid || o_result.ready;

    assign i_frame.ready = (r_state == S_IDLE);
    assign i_cfg.ready   = 1'b1;

    assign w_sq_ctl  = '{load: w_accept,           step: (r_state == S_SQ)};
    assign w_div_ctl = '{load: (r_state == S_LOAD), step: (r_state == S_DIV)};

    // landmark fields widened so that x and y selects stay in range
    assign w_pts[0]  = {8'b0, i_frame.data.left_p0};
    assign w_pts[1]  = {8'b0, i_frame.data.left_p1};
    assign w_pts[2]  = {8'b0, i_frame.data.left_p2};
    assign w_pts[3]  = {8'b0, i_frame.data.left_p3};
    assign w_pts[4]  = {8'b0, i_frame.data.left_p4};
    assign w_pts[5]  = {8'b0, i_frame.data.left_p5};
    assign w_pts[6]  = {8'b0, i_frame.data.right_p0};
    assign w_pts[7]  = {8'b0, i_frame.data.right_p1};
    assign w_pts[8]  = {8'b0, i_frame.data.right_p2};
    assign w_pts[9]  = {8'b0, i_frame.data.right_p3};
    assign w_pts[10] = {8'b0, i_frame.data.right_p4};
    assign w_pts[11] = {8'b0, i_frame.data.right_p5};

    // squarer lanes: per eye, pairs A (p1,p5), B (p2,p4), C (p0,p3), x then y
    for (genvar e = 0; e < 2; e++) begin : g_eye
        for (genvar k = 0; k < 3; k++) begin : g_pair
            for (genvar a = 0; a < 2; a++) begin : g_axis
                localparam int PA = e*6 + ((k == 0) ? 1 : (k == 1) ? 2 : 0);
                localparam int PB = e*6 + ((k == 0) ? 5 : (k == 1) ? 4 : 3);
                localparam int LN = e*6 + k*2 + a;

                logic [CB-1:0] w_ca;
                logic [CB-1:0] w_cb;
                logic [CB-1:0] w_d;

                assign w_ca = w_pts[PA][a*CB +: CB];
                assign w_cb = w_pts[PB][a*CB +: CB];
                assign w_d  = (w_ca >= w_cb) ? (w_ca - w_cb) : (w_cb - w_ca);

                ecad_sqr #(
                    .COORD_BITS (CB)
                ) u_sqr (
                    .i_clk (i_clk),
                    .i_ctl (w_sq_ctl),
                    .i_d   (w_d),
                    .o_sq  (w_sq[LN])
                );
            end
        end

        assign n_ab[e] = (2*CB+2)'(w_sq[e*6+0]) + (2*CB+2)'(w_sq[e*6+1])
                       + (2*CB+2)'(w_sq[e*6+2]) + (2*CB+2)'(w_sq[e*6+3]);
        assign n_c[e]  = (2*CB+1)'(w_sq[e*6+4]) + (2*CB+1)'(w_sq[e*6+5]);

        ecad_div #(
            .COORD_BITS      (CB),
            .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
        ) u_div (
            .i_clk (i_clk),
            .i_ctl (w_div_ctl),
            .i_ab  (r_ab[e]),
            .i_c   (r_c[e]),
            .o_q   (w_ratio[e])
        );
    end

    // average, threshold and closed-frame counter
    always_comb begin
        n_avg_sum = {1'b0, w_ratio[0]} + {1'b0, w_ratio[1]};
        n_avg     = n_avg_sum[RATIO_W:1];
        n_closed  = (n_avg < r_ratio_threshold);
        if (!n_closed) begin
            n_count = '0;
        end else if (r_closed_frames == COUNT_MAX) begin
            n_count = r_closed_frames;
        end else begin
            n_count = r_closed_frames + COUNT_W'(1);
        end
        n_alarm = n_closed && (n_count >= r_alarm_frames);
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio_threshold <= RATIO_THRESHOLD_RST;
            r_alarm_frames    <= ALARM_FRAMES_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.data.index)
                REG_RATIO_THRESHOLD: r_ratio_threshold <= RATIO_W'(i_cfg.data.value);
                REG_ALARM_FRAMES:    r_alarm_frames    <= COUNT_W'(i_cfg.data.value);
                default: ;
            endcase
        end
    end

    // sequencer, counter state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_cnt           <= '0;
            r_out_valid     <= 1'b0;
            r_closed_frames <= '0;
        end else begin
            // in S_DONE the output register is either refilled or left waiting
            if (r_out_valid && o_result.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_SQ;
                        r_cnt   <= '0;
                    end
                end
                S_SQ: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(CB-1)) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_state <= S_DIV;
                    r_cnt   <= '0;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(RATIO_W-1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // commit only once the output register can take the beat
                    if (w_out_free) begin
                        r_out_valid     <= 1'b1;
                        r_closed_frames <= n_count;
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_SUM) begin
            r_ab[0] <= n_ab[0];
            r_ab[1] <= n_ab[1];
            r_c[0]  <= n_c[0];
            r_c[1]  <= n_c[1];
        end
        if (r_state == S_DONE && w_out_free) begin
            r_out.avg_ratio    <= n_avg;
            r_out.eye_closed   <= n_closed;
            r_out.closed_count <= n_count;
            r_out.alarm        <= n_alarm;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

endmodule

// File: tb/sv/ecad_frame_judge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecad_frame_judge
// watches the frame, result and register channels of the eye-closure alarm
// detector, works out the verdict for each frame and compares it with the
// result beats in order
// ----------------------------------------------------------------------------
module ecad_frame_judge (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_frame_valid,
    input  logic              i_frame_ready,
    input  ecad_pkg::t_frame  i_frame_data,
    input  logic              i_result_valid,
    input  logic              i_result_ready,
    input  ecad_pkg::t_result i_result_data,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  ecad_pkg::t_cfg    i_cfg_data,
    output int                o_fail_count,
    output int                o_open_verdicts,
    output int                o_results_checked,
    output int                o_closed_seen,
    output int                o_alarm_seen
);
    import ecad_pkg::*;

    localparam int CW = COORD_BITS_DEF;
    localparam int FW = RATIO_FRAC_BITS_DEF;

    logic [RATIO_W-1:0] ratio_limit;
    logic [COUNT_W-1:0] alarm_need;
    logic [COUNT_W-1:0] closed_run;
    t_result            verdict_q[$];
    int                 mismatches;
    int                 checked;
    int                 closed_seen;
    int                 alarm_seen;

    function automatic logic [2*CW+2:0] dist_sq(logic [FIELD_W-1:0] p, logic [FIELD_W-1:0] q);
        logic [CW-1:0] dx;
        logic [CW-1:0] dy;
        dx = (p[CW-1:0] >= q[CW-1:0]) ? p[CW-1:0] - q[CW-1:0] : q[CW-1:0] - p[CW-1:0];
        dy = (p[2*CW-1:CW] >= q[2*CW-1:CW]) ? p[2*CW-1:CW] - q[2*CW-1:CW]
                                            : q[2*CW-1:CW] - p[2*CW-1:CW];
        return (2*CW+3)'(dx) * (2*CW+3)'(dx) + (2*CW+3)'(dy) * (2*CW+3)'(dy);
    endfunction

    // (A+B)/(2C) with FW fraction bits, saturating, max on zero width
    function automatic logic [RATIO_W-1:0] eye_ratio(
        logic [FIELD_W-1:0] p0, logic [FIELD_W-1:0] p1, logic [FIELD_W-1:0] p2,
        logic [FIELD_W-1:0] p3, logic [FIELD_W-1:0] p4, logic [FIELD_W-1:0] p5
    );
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] q;
        a = 64'(dist_sq(p1, p5));
        b = 64'(dist_sq(p2, p4));
        c = 64'(dist_sq(p0, p3));
        if (c == 0) begin
            return RATIO_MAX;
        end
        q = ((a + b) << FW) / (c * 2);
        if (q > 64'(RATIO_MAX)) begin
            return RATIO_MAX;
        end
        return q[RATIO_W-1:0];
    endfunction

    // verdict for one frame, advances the closed-frame run
    function automatic t_result judge_frame(t_frame f);
        logic [RATIO_W-1:0] left;
        logic [RATIO_W-1:0] right;
        logic [RATIO_W:0]   total;
        t_result            r;
        left  = eye_ratio(f.left_p0, f.left_p1, f.left_p2, f.left_p3, f.left_p4, f.left_p5);
        right = eye_ratio(f.right_p0, f.right_p1, f.right_p2, f.right_p3, f.right_p4,
                          f.right_p5);
        total = {1'b0, left} + {1'b0, right};
        r.avg_ratio  = total[RATIO_W:1];
        r.eye_closed = r.avg_ratio < ratio_limit;
        if (r.eye_closed) begin
            if (closed_run != COUNT_MAX) begin
                closed_run = closed_run + COUNT_W'(1);
            end
        end else begin
            closed_run = '0;
        end
        r.closed_count = closed_run;
        r.alarm        = r.eye_closed && (closed_run >= alarm_need);
        return r;
    endfunction

    function automatic void match_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            ratio_limit = RATIO_THRESHOLD_RST;
            alarm_need  = ALARM_FRAMES_RST;
            closed_run  = '0;
            verdict_q.delete();
            mismatches  = 0;
            checked     = 0;
            closed_seen = 0;
            alarm_seen  = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_data.index)
                    REG_RATIO_THRESHOLD: ratio_limit = i_cfg_data.value;
                    REG_ALARM_FRAMES:    alarm_need  = i_cfg_data.value;
                    default: ;
                endcase
            end
            if (i_frame_valid && i_frame_ready) begin
                verdict_q.insert(verdict_q.size(), judge_frame(i_frame_data));
            end
            if (i_result_valid && i_result_ready) begin
                if (verdict_q.size() == 0) begin
                    $error("result beat with no frame outstanding");
                    mismatches++;
                end else begin
                    want = verdict_q.pop_front();
                    match_field("avg_ratio", want.avg_ratio, i_result_data.avg_ratio);
                    match_field("eye_closed", want.eye_closed, i_result_data.eye_closed);
                    match_field("closed_count", want.closed_count,
                                i_result_data.closed_count);
                    match_field("alarm", want.alarm, i_result_data.alarm);
                    checked++;
                    closed_seen += want.eye_closed;
                    alarm_seen  += want.alarm;
                end
            end
        end
        o_fail_count      <= mismatches;
        o_open_verdicts   <= verdict_q.size();
        o_results_checked <= checked;
        o_closed_seen     <= closed_seen;
        o_alarm_seen      <= alarm_seen;
    end

endmodule

// File: tb/sv/eye_closure_alarm_detector_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eye_closure_alarm_detector_test
// frame stimulus and verdict for the eye-closure alarm detector
// ----------------------------------------------------------------------------
// Drives landmark frames and register writes into the detector, with random
// back-pressure on the result channel, and leaves prediction and comparison
// to ecad_frame_judge. A directed set covers extreme coordinates, zero eye
// width and ratio overflow; random phases then run mostly plausible eye
// shapes in runs of closed and open frames under several threshold and
// alarm length settings, with some raw noise and degenerate eyes mixed in.
// ----------------------------------------------------------------------------
module eye_closure_alarm_detector_test;
    import ecad_pkg::*;

    // drain time after the last result, with margin over the result latency
    localparam int DRAIN_CYCLES   = 48;
    // cycles in a row with no beat on any channel before giving up
    localparam int WATCHDOG_LIMIT = 2000;

    // indexes outside the register map, writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = CFG_IDX_W'(15);

    logic i_clk;
    logic i_rst_n;

    ecad_chan_if #(.T(t_frame))  frame_ch ();
    ecad_chan_if #(.T(t_result)) result_ch ();
    ecad_chan_if #(.T(t_cfg))    cfg_ch ();

    int  fail_count;
    int  open_verdicts;
    int  results_checked;
    int  closed_seen;
    int  alarm_seen;
    int  frames_sent;
    int  settings_used;
    int  quiet_cycles = 0;
    bit  idle_on;

    eye_closure_alarm_detector dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_frame  (frame_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    ecad_frame_judge judge (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_frame_valid     (frame_ch.valid),
        .i_frame_ready     (frame_ch.ready),
        .i_frame_data      (frame_ch.data),
        .i_result_valid    (result_ch.valid),
        .i_result_ready    (result_ch.ready),
        .i_result_data     (result_ch.data),
        .i_cfg_valid       (cfg_ch.valid),
        .i_cfg_ready       (cfg_ch.ready),
        .i_cfg_data        (cfg_ch.data),
        .o_fail_count      (fail_count),
        .o_open_verdicts   (open_verdicts),
        .o_results_checked (results_checked),
        .o_closed_seen     (closed_seen),
        .o_alarm_seen      (alarm_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result back-pressure: random stall bursts while idling is on
    initial begin
        int stall;
        stall = 0;
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!i_rst_n) begin
                result_ch.ready = 1'b0;
            end else if (stall > 0) begin
                stall--;
                result_ch.ready = 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 12) - 1;
                result_ch.ready = 1'b0;
            end else begin
                result_ch.ready = 1'b1;
            end
        end
    end

    // watchdog: a stuck handshake on every channel ends the run
    always @(posedge i_clk) begin
        if ((frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $error("no beat for %0d cycles, %0d results still outstanding",
                   WATCHDOG_LIMIT, open_verdicts);
            $display("eye_closure_alarm_detector_test failed");
            $finish;
        end
    end

    function automatic logic [FIELD_W-1:0] pack_point(int x, int y);
        return {12'(y), 12'(x)};
    endfunction

    // plausible eye: corners w apart, lids h above and below the corner line,
    // so the ratio lands near 4*(h/w)^2
    function automatic logic [6*FIELD_W-1:0] eye_points(bit closed);
        int w;
        int h;
        int q;
        int cx;
        int cy;
        w  = $urandom_range(12, 1000);
        h  = closed ? w * $urandom_range(0, 12) / 100 : w * $urandom_range(18, 45) / 100;
        q  = w / 6;
        cx = $urandom_range(600, 3495);
        cy = $urandom_range(500, 3595);
        return {pack_point(cx - w / 2 + $urandom_range(0, 2), cy + $urandom_range(0, 2)),
                pack_point(cx - q, cy - h),
                pack_point(cx + q, cy - h - $urandom_range(0, 2)),
                pack_point(cx + w / 2, cy),
                pack_point(cx + q + $urandom_range(0, 2), cy + h),
                pack_point(cx - q, cy + h)};
    endfunction

    function automatic t_frame shaped_frame(bit closed);
        return t_frame'({eye_points(closed), eye_points(closed)});
    endfunction

    function automatic t_frame noise_frame();
        logic [$bits(t_frame)-1:0] v;
        for (int i = 0; i < 12; i++) begin
            v[i*FIELD_W +: FIELD_W] = FIELD_W'($urandom);
        end
        return t_frame'(v);
    endfunction

    // one frame beat, with an optional sender gap in front of it
    task automatic push_frame(t_frame f);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            frame_ch.valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        frame_ch.valid = 1'b1;
        frame_ch.data  = f;
        do @(posedge i_clk); while (!frame_ch.ready);
        @(negedge i_clk);
        frames_sent++;
    endtask

    // stop sending and wait for every outstanding result, then let the
    // pipeline run dry
    task automatic settle();
        frame_ch.valid = 1'b0;
        while (open_verdicts != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid       = 1'b1;
        cfg_ch.data.index  = idx;
        cfg_ch.data.value  = val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic apply_setting(logic [RATIO_W-1:0] limit, logic [COUNT_W-1:0] need, bit idle);
        settle();
        write_reg(REG_RATIO_THRESHOLD, limit);
        write_reg(REG_ALARM_FRAMES, need);
        settings_used++;
        idle_on = idle;
    endtask

    // mostly runs of closed and open eyes, some noise and degenerate eyes
    task automatic run_phase(int n_items, int longest_closed);
        int     done;
        int     len;
        int     pick;
        t_frame f;
        done = 0;
        while (done < n_items) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                len = $urandom_range(1, longest_closed);
                repeat (len) push_frame(shaped_frame(1'b1));
                done += len;
            end else if (pick < 8) begin
                len = $urandom_range(1, 5);
                repeat (len) push_frame(shaped_frame(1'b0));
                done += len;
            end else if (pick == 8) begin
                push_frame(noise_frame());
                done++;
            end else begin
                f = shaped_frame(bit'($urandom_range(0, 1)));
                case ($urandom_range(0, 2))
                    0: f.left_p3 = f.left_p0;               // zero width, left
                    1: f.right_p3 = f.right_p0;             // zero width, right
                    default: f.left_p3 = f.left_p0 ^ 24'h1; // width 1, ratio mostly overflows
                endcase
                push_frame(f);
                done++;
            end
        end
    endtask

    initial begin
        t_frame f;
        i_rst_n        = 1'b0;
        idle_on        = 1'b1;
        frames_sent    = 0;
        settings_used  = 1;
        frame_ch.valid = 1'b0;
        frame_ch.data  = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.data    = '0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed frames at the reset settings
        push_frame(t_frame'({12{24'h000000}}));  // every point at the origin
        push_frame(t_frame'({12{24'hFFFFFF}}));  // every point at the far corner
        push_frame(t_frame'({12{24'hAAAAAA}}));
        push_frame(t_frame'({12{24'h555555}}));

        // widest possible eye with lids shut: ratio zero, run of closed frames
        f = '0;
        f.left_p3  = '1;
        f.right_p3 = '1;
        repeat (3) push_frame(f);
        push_frame(shaped_frame(1'b0));  // open frame clears the run

        // corners one apart and lids at opposite extremes: ratio saturates
        f = '0;
        f.left_p3  = 24'h000001;
        f.left_p5  = '1;
        f.left_p2  = '1;
        f.right_p3 = 24'h001000;
        f.right_p1 = '1;
        f.right_p4 = '1;
        push_frame(f);

        // zero-width left eye beside a closed right eye
        f = shaped_frame(1'b1);
        f.left_p3 = f.left_p0;
        push_frame(f);

        // y-only widths on both eyes, right corners in reversed order
        f = '0;
        f.left_p3  = 24'hFFF000;
        f.left_p1  = 24'h000FFF;
        f.right_p0 = '1;
        f.right_p3 = 24'h000FFF;
        f.right_p2 = 24'hFFF000;
        push_frame(f);

        repeat (3) push_frame(shaped_frame(1'b1));
        push_frame(noise_frame());
        push_frame(shaped_frame(1'b1));

        // random phases, long closed runs reach the default alarm length
        run_phase(160, 60);

        apply_setting(RATIO_W'(369), COUNT_W'(3), 1'b1);
        run_phase(160, 8);

        // threshold zero: nothing is ever closed; no idling in this stretch
        apply_setting(RATIO_W'(0), COUNT_W'(1), 1'b0);
        write_reg(REG_UNMAPPED_LO, CFG_DATA_W'($urandom));
        write_reg(REG_UNMAPPED_HI, CFG_DATA_W'($urandom));
        run_phase(160, 6);

        // top threshold with zero alarm length: alarm on every closed frame
        apply_setting(RATIO_MAX, COUNT_W'(0), 1'b1);
        run_phase(160, 6);

        apply_setting(RATIO_W'($urandom_range(300, 500)), COUNT_W'($urandom_range(2, 12)),
                      1'b1);
        run_phase(160, 14);

        // longest alarm length: never reached
        apply_setting(RATIO_W'(1000), COUNT_MAX, 1'b1);
        write_reg(REG_UNMAPPED_LO, CFG_DATA_W'($urandom));
        run_phase(160, 10);

        // last stretch runs with no idling on either side
        apply_setting(RATIO_THRESHOLD_RST, COUNT_W'(1), 1'b0);
        run_phase(160, 6);

        settle();

        $display("covered %0d frames under %0d register settings, incl. zero-width eyes",
                 frames_sent, settings_used);
        $display("checked %0d results: %0d with eyes closed, %0d with alarm raised",
                 results_checked, closed_seen, alarm_seen);
        if (fail_count == 0 && open_verdicts == 0) begin
            $display("eye_closure_alarm_detector_test passed");
        end else begin
            $display("eye_closure_alarm_detector_test failed");
        end
        $finish;
    end

endmodule

// File: sim.f
src/ecad_pkg.sv
src/ecad_chan_if.sv
src/ecad_sqr.sv
src/ecad_div.sv
src/eye_closure_alarm_detector.sv
tb/sv/ecad_frame_judge.sv
tb/sv/eye_closure_alarm_detector_test.sv
